/* hdl/ljt_pkg.sv */
// ----------------------------------------------------------------------------
// ljt_pkg
// Types and codes shared by the line junction tracker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ljt_pkg;

    localparam int unsigned NumSensors  = 5;
    localparam int unsigned SampleWidth = 8;

    // Five samples, sensor 0 (leftmost) in the lowest byte
    typedef logic [NumSensors-1:0][SampleWidth-1:0] frame_t;

    typedef enum logic [2:0] {
        MODE_SCAN           = 3'd0,
        MODE_LEFT           = 3'd1,
        MODE_STRAIGHT_RIGHT = 3'd2,
        MODE_RIGHT          = 3'd3,
        MODE_STOPPED        = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        EV_LEFT     = 2'd0,
        EV_STRAIGHT = 2'd1,
        EV_RIGHT    = 2'd2,
        EV_STOP     = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        CLS_PLUS           = 3'd0,
        CLS_T              = 3'd1,
        CLS_RIGHT_STRAIGHT = 3'd2,
        CLS_LEFT_STRAIGHT  = 3'd3,
        CLS_ONLY_RIGHT     = 3'd4,
        CLS_ONLY_LEFT      = 3'd5,
        CLS_END            = 3'd6,
        CLS_UNKNOWN        = 3'd7
    } class_t;

    // Register indexes on the configuration port
    localparam logic REG_BLACK = 1'b0;
    localparam logic REG_WHITE = 1'b1;

    // Threshold reset values (0.4 and 0.7 scaled by 256)
    localparam logic [SampleWidth-1:0] BlackReset = 8'd102;
    localparam logic [SampleWidth-1:0] WhiteReset = 8'd179;

    // State update from the core
    typedef struct packed {
        mode_t      mode_next;
        logic [1:0] heading_next;
        logic       prev_we;
    } ljt_update_t;

    // Result from the core
    typedef struct packed {
        logic       valid;
        event_t     kind;
        class_t     cls;
        logic [1:0] heading;
    } ljt_result_t;

endpackage

`default_nettype wire

/* hdl/line_junction_tracker_top.sv */
// ----------------------------------------------------------------------------
// line_junction_tracker_top
// Follows junctions on a line grid from five-sensor frames, emits turn events.
// ----------------------------------------------------------------------------
//  channel   dir  payload                                       handshake
//  s_axis    in   sensor_0..sensor_4 (tdata 40b)                tvalid/tready
//  m_axis    out  junction_class, heading (tdata); kind (tuser) tvalid/tready
//  apb       in   black_threshold @0x0, white_threshold @0x4    psel/penable
//
//  One frame per cycle while m_axis_tready holds: an input register feeds the
//  core logic, whose result for the frame then lands in an output register.
//  Tracking state (mode, heading, previous frame) updates as the frame leaves
//  the input register, so consecutive frames need no bubble.
//  A pending result stalls only the frame behind it; s_axis_tready stays high
//  while the input register can move on.
//  rst_n is asynchronous: scanning, heading north, previous frame zero,
//  thresholds 102 and 179. A stop event freezes tracking until reset.
// ----------------------------------------------------------------------------
`default_nettype none

module line_junction_tracker_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input frames
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // sensor_0..sensor_4, 8b each from bit 0
    // events
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // junction_class[2:0], heading[4:3], zero pad
    output logic [1:0]       m_axis_tuser,   // event_kind[1:0]
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // input stage
    logic                 in_valid_reg;
    ljt_pkg::frame_t      in_frame_reg;
    logic                 advance;

    // tracking state
    ljt_pkg::mode_t       mode_reg;
    logic [1:0]           heading_reg;
    ljt_pkg::frame_t      prev_reg;
    logic [7:0]           black_reg;
    logic [7:0]           white_reg;

    // output stage
    logic                 out_valid_reg;
    logic                 out_valid_next;
    ljt_pkg::event_t      out_kind_reg;
    ljt_pkg::class_t      out_cls_reg;
    logic [1:0]           out_heading_reg;

    ljt_pkg::ljt_update_t upd;
    ljt_pkg::ljt_result_t res;
    logic                 cfg_write;

    // The frame in the input register moves once the output slot is free
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_frame_reg <= s_axis_tdata;
    end

    ljt_core u_core (
        .frame      (in_frame_reg),
        .prev_frame (prev_reg),
        .mode       (mode_reg),
        .heading    (heading_reg),
        .black_th   (black_reg),
        .white_th   (white_reg),
        .upd        (upd),
        .res        (res)
    );

    // tracking state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= ljt_pkg::MODE_SCAN;
            heading_reg <= 2'd0;
            prev_reg    <= '0;
        end
        else if (advance)
        begin
            mode_reg    <= upd.mode_next;
            heading_reg <= upd.heading_next;
            if (upd.prev_we)
                prev_reg <= in_frame_reg;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = res.valid;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.valid)
        begin
            out_kind_reg    <= res.kind;
            out_cls_reg     <= res.cls;
            out_heading_reg <= res.heading;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_heading_reg, out_cls_reg};
    assign m_axis_tuser  = out_kind_reg;

    // configuration registers, decoded on address bit 2
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            black_reg <= ljt_pkg::BlackReset;
            white_reg <= ljt_pkg::WhiteReset;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == ljt_pkg::REG_BLACK)
                black_reg <= pwdata[7:0];
            else
                white_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == ljt_pkg::REG_WHITE) ? {24'd0, white_reg}
                                                      : {24'd0, black_reg};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    // stopped is terminal
    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == ljt_pkg::MODE_STOPPED |=> mode_reg == ljt_pkg::MODE_STOPPED)
        else $error("tracker left stopped mode");

    // heading moves only together with a fresh turn event
    a_heading_turn: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(heading_reg) |-> out_valid_reg && !$past(out_valid_reg && !m_axis_tready) &&
        (out_kind_reg == ljt_pkg::EV_LEFT || out_kind_reg == ljt_pkg::EV_RIGHT))
        else $error("heading changed without a turn event");

    // a stop event implies the stopped mode
    a_stop_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_kind_reg == ljt_pkg::EV_STOP |-> mode_reg == ljt_pkg::MODE_STOPPED)
        else $error("stop event without stopped mode");

    // the input register drains whenever the output slot is empty
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty output");

endmodule

`default_nettype wire

/* hdl/ljt_core.sv */
// ----------------------------------------------------------------------------
// ljt_core
// Threshold tests, junction classification and mode transition for one frame.
// ----------------------------------------------------------------------------
`default_nettype none

module ljt_core (
    input  wire ljt_pkg::frame_t  frame,
    input  wire ljt_pkg::frame_t  prev_frame,
    input  wire ljt_pkg::mode_t   mode,
    input  wire logic [1:0]       heading,
    input  wire logic [7:0]       black_th,
    input  wire logic [7:0]       white_th,
    output ljt_pkg::ljt_update_t  upd,
    output ljt_pkg::ljt_result_t  res
);

    logic [4:0] wht;        // sample > white
    logic [4:0] blk;        // sample < black
    logic [4:0] blw;        // sample < white
    logic [4:0] p_wht;
    logic [4:0] p_blk;
    logic [4:0] p_blw;
    logic       exit_pat;
    logic       node_pat;
    logic       all_black;
    ljt_pkg::class_t cls_cur;
    ljt_pkg::class_t cls_prev;

    function automatic ljt_pkg::class_t classify(
        input logic [4:0] w,
        input logic [4:0] b,
        input logic [4:0] bw
    );
        ljt_pkg::class_t c;
        priority if (&w)                          c = ljt_pkg::CLS_PLUS;
        else if (&w[3:0] && bw[4])                c = ljt_pkg::CLS_T;
        else if (w[2] && w[3] && w[4])            c = ljt_pkg::CLS_RIGHT_STRAIGHT;
        else if (w[0] && w[1] && w[4])            c = ljt_pkg::CLS_LEFT_STRAIGHT;
        else if (w[3])                            c = ljt_pkg::CLS_ONLY_RIGHT;
        else if (w[0])                            c = ljt_pkg::CLS_ONLY_LEFT;
        else if (&b)                              c = ljt_pkg::CLS_END;
        else                                      c = ljt_pkg::CLS_UNKNOWN;
        return c;
    endfunction

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            wht[i]   = frame[i] > white_th;
            blk[i]   = frame[i] < black_th;
            blw[i]   = frame[i] < white_th;
            p_wht[i] = prev_frame[i] > white_th;
            p_blk[i] = prev_frame[i] < black_th;
            p_blw[i] = prev_frame[i] < white_th;
        end
    end

    assign exit_pat  = blk[0] && wht[1] && wht[2] && blk[3] && wht[4];
    assign node_pat  = &wht[3:0];
    assign all_black = &blk;
    assign cls_cur   = classify(wht, blk, blw);
    assign cls_prev  = classify(p_wht, p_blk, p_blw);

    // Next state
    always_comb
    begin
        upd.mode_next    = mode;
        upd.heading_next = heading;
        upd.prev_we      = 1'b0;
        unique case (mode)
            ljt_pkg::MODE_STOPPED:
            begin
                upd.mode_next = ljt_pkg::MODE_STOPPED;
            end
            ljt_pkg::MODE_LEFT:
            begin
                if (exit_pat)
                begin
                    upd.heading_next = heading - 2'd1;
                    upd.mode_next    = ljt_pkg::MODE_SCAN;
                end
                else
                begin
                    upd.prev_we = 1'b1;
                end
            end
            ljt_pkg::MODE_STRAIGHT_RIGHT:
            begin
                if ((blw[0] && blw[3]) || node_pat)
                    upd.mode_next = ljt_pkg::MODE_SCAN;
                else
                    upd.prev_we = 1'b1;
            end
            ljt_pkg::MODE_RIGHT:
            begin
                if (exit_pat)
                begin
                    upd.heading_next = heading + 2'd1;
                    upd.mode_next    = ljt_pkg::MODE_SCAN;
                end
                else if (node_pat)
                    upd.mode_next = ljt_pkg::MODE_SCAN;
                else
                    upd.prev_we = 1'b1;
            end
            default:
            begin
                // scanning, and any unused code
                priority if (wht[0] && wht[1] && wht[2])
                    upd.mode_next = ljt_pkg::MODE_LEFT;
                else if (blk[0] && (&wht[4:1]))
                    upd.mode_next = ljt_pkg::MODE_STRAIGHT_RIGHT;
                else if ((wht[1] && wht[2] && wht[3]) || (wht[2] && wht[3] && blw[4]))
                    upd.mode_next = ljt_pkg::MODE_RIGHT;
                else if (all_black)
                    upd.mode_next = ljt_pkg::MODE_STOPPED;
                else
                    upd.mode_next = ljt_pkg::MODE_SCAN;
            end
        endcase
    end

    // Result
    always_comb
    begin
        res.valid   = 1'b0;
        res.kind    = ljt_pkg::EV_STOP;
        res.cls     = cls_prev;
        res.heading = upd.heading_next;
        unique case (mode)
            ljt_pkg::MODE_STOPPED:
            begin
                res.valid = 1'b0;
            end
            ljt_pkg::MODE_LEFT:
            begin
                res.valid = exit_pat;
                res.kind  = ljt_pkg::EV_LEFT;
            end
            ljt_pkg::MODE_STRAIGHT_RIGHT:
            begin
                res.valid = blw[0] && blw[3];
                res.kind  = ljt_pkg::EV_STRAIGHT;
            end
            ljt_pkg::MODE_RIGHT:
            begin
                res.valid = exit_pat;
                res.kind  = ljt_pkg::EV_RIGHT;
            end
            default:
            begin
                res.valid = (upd.mode_next == ljt_pkg::MODE_STOPPED);
                res.kind  = ljt_pkg::EV_STOP;
                res.cls   = cls_cur;
            end
        endcase
    end

endmodule

`default_nettype wire
